// ===== rtl/tmtw_pkg.sv =====
package tmtw_pkg;

   localparam int OP_W     = 2;
   localparam int CH_W     = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 8;
   localparam int PROMPT_W = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic [CELL_W-1:0] cell_type;

   localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [COLOR_W-1:0]  COLOR_RESET  = 8'd31;
   localparam logic [PROMPT_W-1:0] PROMPT_RESET = 7'd2;
   localparam cell_type            RESET_BLANK  = {COLOR_RESET, CH_SPACE};

   localparam logic REG_TEXT_COLOR    = 1'b0;
   localparam logic REG_PROMPT_COLUMN = 1'b1;

endpackage

// ===== rtl/tmtw_cell_ram.sv =====
module tmtw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tmtw_pkg::cell_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tmtw_pkg::cell_type  rd_data
);

   tmtw_pkg::cell_type mem_ff [DEPTH];
   tmtw_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_mode_terminal_writer.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  op, ch, read_row, read_col
// rsp       out        rsp_valid/rsp_ready  cursor_row, cursor_col, cell_value
// csr       in         APB, pready high     text_color (0x0), prompt_column (0x4)
//
// Put, backspace and read each accept the item and access the cell memory in ST_IDLE, then
// move the result into the output register in ST_POST once that register is free.
// A scroll also blanks one row in ST_SWEEP; clear blanks every cell.
// After reset all ROWS*COLUMNS cells (2000 by default) of the cell memory are blanked
// before the first item is accepted; configuration writes are taken meanwhile.
// Rows are kept as a circular buffer, so a scroll moves the top pointer instead of data.
module text_mode_terminal_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tmtw_pkg::OP_W-1:0]           req_op,
   input  logic [tmtw_pkg::CH_W-1:0]           req_ch,
   input  logic [tmtw_pkg::ROW_W-1:0]          req_read_row,
   input  logic [tmtw_pkg::COL_W-1:0]          req_read_col,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tmtw_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [tmtw_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tmtw_pkg::CELL_W-1:0]         rsp_cell_value,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tmtw_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [tmtw_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [tmtw_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int RW1   = RW + 1;
   localparam int CW    = $clog2(COLUMNS);
   localparam int CW1   = CW + 1;
   localparam int PRW   = tmtw_pkg::ROW_W;
   localparam int PCW   = tmtw_pkg::COL_W;
   localparam int PPW   = tmtw_pkg::PROMPT_W;
   localparam int PCLW  = tmtw_pkg::COLOR_W;
   localparam int PDW   = tmtw_pkg::CSR_DW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_POST  = 2'd2;

   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                              input logic [RW-1:0] t);
      logic [RW1-1:0] sum;
      sum = {1'b0, r} + {1'b0, t};
      if (sum >= RW1'(ROWS)) begin
         sum = sum - RW1'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] pr,
                                               input logic [CW-1:0] c);
      return AW'(pr) * AW'(COLUMNS) + AW'(c);
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [RW-1:0]       top_ff, top_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [PCLW-1:0]     color_ff, color_in;
   logic [PPW-1:0]      prompt_ff, prompt_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [AW-1:0]       sweep_last_ff, sweep_last_in;
   tmtw_pkg::cell_type  sweep_data_ff, sweep_data_in;
   logic                sweep_post_ff, sweep_post_in;
   logic                read_hit_ff, read_hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRW-1:0]      rsp_row_ff, rsp_row_in;
   logic [PCW-1:0]      rsp_col_ff, rsp_col_in;
   tmtw_pkg::cell_type  rsp_cell_ff, rsp_cell_in;

   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   tmtw_pkg::cell_type  mem_wd;
   logic                mem_re;
   logic [AW-1:0]       mem_ra;
   tmtw_pkg::cell_type  mem_rd;

   logic                accept;
   logic                is_newline;
   logic                is_tab;
   logic [CW1-1:0]      col_step;
   logic                wrap;
   logic [RW-1:0]       cur_prow;
   logic [CW-1:0]       bs_col;
   logic [CW-1:0]       clr_col;
   logic                rd_in_range;
   logic [RW-1:0]       top_step;
   logic [AW-1:0]       scroll_start;
   tmtw_pkg::cell_type  blank;
   logic                csr_wr;

   tmtw_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_ch == tmtw_pkg::CH_NEWLINE);
   assign is_tab     = (req_ch == tmtw_pkg::CH_TAB);
   assign col_step   = {1'b0, col_ff} + (is_tab ? CW1'(2) : CW1'(1));
   assign wrap       = is_newline || (col_step >= CW1'(COLUMNS));
   assign cur_prow   = phys_row(row_ff, top_ff);
   assign bs_col     = ((PPW'(col_ff) != prompt_ff) && (col_ff != '0)) ? col_ff - CW'(1)
                                                                       : col_ff;
   assign clr_col    = (32'(prompt_ff) < COLUMNS) ? CW'(prompt_ff) : LAST_COL;
   assign rd_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
   assign top_step   = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
   assign scroll_start = cell_addr(top_ff, '0);
   assign blank      = {color_ff, tmtw_pkg::CH_SPACE};
   assign mem_ra     = cell_addr(phys_row(RW'(req_read_row), top_ff), CW'(req_read_col));

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      col_in        = col_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      sweep_data_in = sweep_data_ff;
      sweep_post_in = sweep_post_ff;
      read_hit_in   = read_hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_cell_in   = rsp_cell_ff;
      mem_we        = 1'b0;
      mem_wa        = sweep_addr_ff;
      mem_wd        = sweep_data_ff;
      mem_re        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_POST;
               read_hit_in = 1'b0;
               case (req_op)
                  tmtw_pkg::OP_PUT: begin
                     if (!is_newline && !is_tab) begin
                        mem_we = 1'b1;
                        mem_wa = cell_addr(cur_prow, col_ff);
                        mem_wd = {color_ff, req_ch};
                     end
                     if (wrap) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           top_in        = top_step;
                           sweep_addr_in = scroll_start;
                           sweep_last_in = scroll_start + ROW_SPAN;
                           sweep_data_in = blank;
                           sweep_post_in = 1'b1;
                           state_in      = ST_SWEEP;
                        end else begin
                           row_in = row_ff + RW'(1);
                        end
                     end else begin
                        col_in = col_step[CW-1:0];
                     end
                  end
                  tmtw_pkg::OP_BACKSPACE: begin
                     col_in = bs_col;
                     mem_we = 1'b1;
                     mem_wa = cell_addr(cur_prow, bs_col);
                     mem_wd = blank;
                  end
                  tmtw_pkg::OP_CLEAR: begin
                     row_in        = '0;
                     top_in        = '0;
                     col_in        = clr_col;
                     sweep_addr_in = '0;
                     sweep_last_in = LAST_CELL;
                     sweep_data_in = blank;
                     sweep_post_in = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                     mem_re      = 1'b1;
                     read_hit_in = rd_in_range;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = sweep_post_ff ? ST_POST : ST_IDLE;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = PRW'(row_ff);
               rsp_col_in   = PCW'(col_ff);
               rsp_cell_in  = read_hit_ff ? mem_rd : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign color_in   = (csr_wr && (csr_paddr[2] == tmtw_pkg::REG_TEXT_COLOR))
                       ? csr_pwdata[PCLW-1:0] : color_ff;
   assign prompt_in  = (csr_wr && (csr_paddr[2] == tmtw_pkg::REG_PROMPT_COLUMN))
                       ? csr_pwdata[PPW-1:0] : prompt_ff;
   assign csr_prdata = (csr_paddr[2] == tmtw_pkg::REG_PROMPT_COLUMN) ? PDW'(prompt_ff)
                                                                      : PDW'(color_ff);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         top_ff        <= '0;
         col_ff        <= '0;
         color_ff      <= tmtw_pkg::COLOR_RESET;
         prompt_ff     <= tmtw_pkg::PROMPT_RESET;
         sweep_addr_ff <= '0;
         sweep_last_ff <= LAST_CELL;
         sweep_data_ff <= tmtw_pkg::RESET_BLANK;
         sweep_post_ff <= 1'b0;
         read_hit_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         col_ff        <= col_in;
         color_ff      <= color_in;
         prompt_ff     <= prompt_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         sweep_data_ff <= sweep_data_in;
         sweep_post_ff <= sweep_post_in;
         read_hit_ff   <= read_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_value = rsp_cell_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS) && (32'(top_ff) < ROWS))
      else $error("Cursor or top row left the screen.");

   a_read_to_post: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == tmtw_pkg::OP_READ) |=> (state_ff == ST_POST))
      else $error("A read item did not go straight to result delivery.");

   a_post_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST) |-> !mem_we)
      else $error("Cell memory written while a result is being delivered.");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_addr_ff <= sweep_last_ff))
      else $error("Blanking pass ran past its last cell.");

endmodule
